// File: rtl/pgf_pkg.sv
// shared widths, reset values and sequencer states for the processor grid factorizer
package pgf_pkg;

   localparam int POINT_W = 16;
   localparam int PROC_W  = 13;
   localparam int PAD_W   = 4;
   localparam int PROD_W  = POINT_W + PROC_W;

   localparam logic [PAD_W-1:0] PAD_RESET = 4'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_LIM_I,
      ST_LIM_J,
      ST_MUL_I,
      ST_MUL_J,
      ST_CMP,
      ST_NEXT,
      ST_DONE
   } pgf_state_type;

endpackage

// File: rtl/pgf_if.sv
// request, response and register-write channels of the processor grid factorizer
interface pgf_req_if import pgf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POINT_W-1:0] points_i;
   logic [POINT_W-1:0] points_j;
   logic [PROC_W-1:0]  proc_count;

   modport source (output valid, output points_i, output points_j, output proc_count,
                   input ready);
   modport sink   (input valid, input points_i, input points_j, input proc_count,
                   output ready);
endinterface

interface pgf_rsp_if import pgf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PROC_W-1:0] procs_i;
   logic [PROC_W-1:0] procs_j;
   logic              found;

   modport source (output valid, output procs_i, output procs_j, output found,
                   input ready);
   modport sink   (input valid, input procs_i, input procs_j, input found,
                   output ready);
endinterface

interface pgf_csr_if import pgf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PAD_W-1:0] padding_width;

   modport source (output valid, output padding_width, input ready);
   modport sink   (input valid, input padding_width, output ready);
endinterface

// File: rtl/processor_grid_factorizer_unit.sv
// processor grid factorizer: divisor search over proc_count with one shared divider and multiplier
// search: for each p1 = 1..proc_count, a bit-serial restoring divide of proc_count by p1,
//   limit checks, and for a valid divisor two products and a compare
// throughput: one request at a time; the next request is taken once the result is in the
//   output register, while that result may still wait for the sink
// reset: synchronous, active high; clears the sequencer and output valid, padding_width goes to 2
module processor_grid_factorizer_unit import pgf_pkg::*; #(
   parameter int MAX_PROCS  = 4096,
   parameter int POINT_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   pgf_req_if.sink  req_ch,
   pgf_rsp_if.source rsp_ch,
   pgf_csr_if.sink  csr_ch
);

   localparam logic [POINT_W-1:0] POINT_MASK = (POINT_BITS >= POINT_W) ?
      {POINT_W{1'b1}} : POINT_W'((33'd1 << POINT_BITS) - 33'd1);
   localparam int CNT_W = $clog2(PROC_W);

   pgf_state_type state_ff, state_in;

   logic [PAD_W-1:0]   pad_ff;
   logic [POINT_W-1:0] ni_ff, ni_in;
   logic [POINT_W-1:0] nj_ff, nj_in;
   logic [PROC_W-1:0]  np_ff, np_in;
   logic [PROC_W-1:0]  p1_ff, p1_in;
   logic [PROC_W-1:0]  rem_ff, rem_in;
   logic [PROC_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [PROD_W-1:0]  prod_i_ff, prod_i_in;
   logic [PROD_W-1:0]  prod_j_ff, prod_j_in;
   logic [PROD_W-1:0]  best_ff, best_in;
   logic [PROC_W-1:0]  best1_ff, best1_in;
   logic [PROC_W-1:0]  best2_ff, best2_in;
   logic               have_ff, have_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PROC_W-1:0]  rsp_procs_i_ff, rsp_procs_i_in;
   logic [PROC_W-1:0]  rsp_procs_j_ff, rsp_procs_j_in;
   logic               rsp_found_ff, rsp_found_in;

   logic [PAD_W-1:0]   pad_eff;
   logic [POINT_W-1:0] mul_a;
   logic [PROC_W-1:0]  mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [PROC_W:0]    div_trial;
   logic               div_ge;
   logic [PROD_W-1:0]  cost;
   logic               req_take;
   logic [PROC_W-1:0]  req_np;

   assign pad_eff = (pad_ff == '0) ? PAD_W'(1) : pad_ff;

   // shared multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LIM_I: begin
            mul_a = POINT_W'(pad_eff);
            mul_b = p1_ff;
         end
         ST_LIM_J: begin
            mul_a = POINT_W'(pad_eff);
            mul_b = quo_ff;
         end
         ST_MUL_I: begin
            mul_a = ni_ff;
            mul_b = quo_ff;
         end
         ST_MUL_J: begin
            mul_a = nj_ff;
            mul_b = p1_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = {{PROC_W{1'b0}}, mul_a} * {{POINT_W{1'b0}}, mul_b};

   // restoring divide step: partial remainder against p1
   assign div_trial = {rem_ff, quo_ff[PROC_W-1]};
   assign div_ge    = (div_trial >= {1'b0, p1_ff});

   assign cost = (prod_i_ff >= prod_j_ff) ? (prod_i_ff - prod_j_ff) : (prod_j_ff - prod_i_ff);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && (state_ff == ST_IDLE);
   assign req_np       = req_ch.proc_count;

   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.procs_i = rsp_procs_i_ff;
   assign rsp_ch.procs_j = rsp_procs_j_ff;
   assign rsp_ch.found   = rsp_found_ff;

   always_comb begin
      state_in       = state_ff;
      ni_in          = ni_ff;
      nj_in          = nj_ff;
      np_in          = np_ff;
      p1_in          = p1_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      bit_cnt_in     = bit_cnt_ff;
      prod_i_in      = prod_i_ff;
      prod_j_in      = prod_j_ff;
      best_in        = best_ff;
      best1_in       = best1_ff;
      best2_in       = best2_ff;
      have_in        = have_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_procs_i_in = rsp_procs_i_ff;
      rsp_procs_j_in = rsp_procs_j_ff;
      rsp_found_in   = rsp_found_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ni_in      = req_ch.points_i & POINT_MASK;
               nj_in      = req_ch.points_j & POINT_MASK;
               np_in      = req_np;
               p1_in      = PROC_W'(1);
               rem_in     = '0;
               quo_in     = req_np;
               bit_cnt_in = '0;
               have_in    = 1'b0;
               // zero or too many processors: nothing to search
               if (req_np == '0 || {4'b0, req_np} > 17'(MAX_PROCS)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in     = div_ge ? PROC_W'(div_trial - {1'b0, p1_ff}) : div_trial[PROC_W-1:0];
            quo_in     = {quo_ff[PROC_W-2:0], div_ge};
            bit_cnt_in = bit_cnt_ff + CNT_W'(1);
            if (bit_cnt_ff == CNT_W'(PROC_W - 1)) begin
               state_in = ST_LIM_I;
            end
         end
         ST_LIM_I: begin
            if (rem_ff != '0 || mul_p > {{PROC_W{1'b0}}, ni_ff}) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_LIM_J;
            end
         end
         ST_LIM_J: begin
            if (mul_p > {{PROC_W{1'b0}}, nj_ff}) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_MUL_I;
            end
         end
         ST_MUL_I: begin
            prod_i_in = mul_p;
            state_in  = ST_MUL_J;
         end
         ST_MUL_J: begin
            prod_j_in = mul_p;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            // first strict minimum wins
            if (!have_ff || cost < best_ff) begin
               best_in  = cost;
               best1_in = p1_ff;
               best2_in = quo_ff;
               have_in  = 1'b1;
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (p1_ff == np_ff) begin
               state_in = ST_DONE;
            end else begin
               p1_in      = p1_ff + PROC_W'(1);
               rem_in     = '0;
               quo_in     = np_ff;
               bit_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_procs_i_in = have_ff ? best1_ff : '0;
               rsp_procs_j_in = have_ff ? best2_ff : '0;
               rsp_found_in   = have_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         pad_ff       <= PAD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
         if (csr_ch.valid) begin
            pad_ff <= csr_ch.padding_width;
         end
      end
   end

   always_ff @(posedge clock) begin
      ni_ff          <= ni_in;
      nj_ff          <= nj_in;
      np_ff          <= np_in;
      p1_ff          <= p1_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      bit_cnt_ff     <= bit_cnt_in;
      prod_i_ff      <= prod_i_in;
      prod_j_ff      <= prod_j_in;
      best_ff        <= best_in;
      best1_ff       <= best1_in;
      best2_ff       <= best2_in;
      rsp_procs_i_ff <= rsp_procs_i_in;
      rsp_procs_j_ff <= rsp_procs_j_in;
      rsp_found_ff   <= rsp_found_in;
   end

endmodule

// File: verif/pgf_split_checker.sv
// channel monitor and result checker for the processor grid factorizer
module pgf_split_checker import pgf_pkg::*; #(
   parameter int MAX_PROCS = 4096
) (
   input logic clock,
   input logic reset,
   pgf_req_if  req_ch,
   pgf_rsp_if  rsp_ch,
   pgf_csr_if  csr_ch,
   output int  mismatch_total,
   output int  waiting_total
);

   typedef struct packed {
      logic [PROC_W-1:0] procs_i;
      logic [PROC_W-1:0] procs_j;
      logic              found;
   } grid_split_type;

   grid_split_type   expected_splits[$];
   grid_split_type   want;
   logic [PAD_W-1:0] pad_copy = PAD_RESET;
   int               errors = 0;

   // squarest divisor pair of np, first strict minimum of |ni*p2 - nj*p1|
   function automatic grid_split_type factor_grid(logic [POINT_W-1:0] ni,
                                                  logic [POINT_W-1:0] nj,
                                                  logic [PROC_W-1:0] np, logic [PAD_W-1:0] pad);
      grid_split_type  best_split;
      int unsigned     pad_eff;
      int unsigned     lim_i;
      int unsigned     lim_j;
      int unsigned     p2;
      longint unsigned lhs;
      longint unsigned rhs;
      longint unsigned cost;
      longint unsigned best_cost;
      best_split = '0;
      best_cost  = 0;
      pad_eff    = (pad == '0) ? 1 : pad;
      lim_i      = ni / pad_eff;
      lim_j      = nj / pad_eff;
      if (np <= MAX_PROCS) begin
         for (int unsigned p1 = 1; p1 <= np; p1++) begin
            if (np % p1 != 0) continue;
            p2 = np / p1;
            if (p1 > lim_i || p2 > lim_j) continue;
            lhs  = 64'(ni) * 64'(p2);
            rhs  = 64'(nj) * 64'(p1);
            cost = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
            if (!best_split.found || cost < best_cost) begin
               best_cost          = cost;
               best_split.procs_i = PROC_W'(p1);
               best_split.procs_j = PROC_W'(p2);
               best_split.found   = 1'b1;
            end
         end
      end
      return best_split;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_splits.delete();
         pad_copy = PAD_RESET;
      end else begin
         // results drain before new requests land, so same-edge traffic stays ordered
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_splits.size() == 0) begin
               $error("unexpected result: procs_i %0d procs_j %0d found %0d",
                      rsp_ch.procs_i, rsp_ch.procs_j, rsp_ch.found);
               errors++;
            end else begin
               want = expected_splits.pop_front();
               if (rsp_ch.procs_i !== want.procs_i) begin
                  $error("procs_i: expected %0d, got %0d", want.procs_i, rsp_ch.procs_i);
                  errors++;
               end
               if (rsp_ch.procs_j !== want.procs_j) begin
                  $error("procs_j: expected %0d, got %0d", want.procs_j, rsp_ch.procs_j);
                  errors++;
               end
               if (rsp_ch.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
                  errors++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready)
            pad_copy = csr_ch.padding_width;
         if (req_ch.valid && req_ch.ready)
            expected_splits.push_back(factor_grid(req_ch.points_i, req_ch.points_j,
                                                  req_ch.proc_count, pad_copy));
      end
      mismatch_total <= errors;
      waiting_total  <= expected_splits.size();
   end

endmodule

// File: verif/processor_grid_factorizer_unit_tb.sv
// stimulus, flow control and verdict for the processor grid factorizer
module processor_grid_factorizer_unit_tb;
   import pgf_pkg::*;

   localparam int MAX_PROCS    = 4096;
   localparam int POINT_BITS   = 16;
   localparam int CYCLE_LIMIT  = 10_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 15;

   logic        clock = 1'b0;
   logic        reset;
   logic        rsp_take = 1'b0;
   logic        hold_go;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          stall_left = 0;
   int unsigned cycle_count = 0;
   int          mismatch_total;
   int          waiting_total;

   pgf_req_if req_ch ();
   pgf_rsp_if rsp_ch ();
   pgf_csr_if csr_ch ();

   assign rsp_ch.ready = rsp_take;

   always #1 clock = ~clock;

   processor_grid_factorizer_unit #(
      .MAX_PROCS  (MAX_PROCS),
      .POINT_BITS (POINT_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pgf_split_checker #(
      .MAX_PROCS (MAX_PROCS)
   ) split_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_total (mismatch_total),
      .waiting_total  (waiting_total)
   );

   // result sink, with a long counted hold-off on request
   always @(posedge clock) begin
      if (hold_go)
         stall_left = HOLD_CYCLES;
      if (reset) begin
         rsp_take <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_take <= 1'b0;
         stall_left--;
      end else begin
         rsp_take <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(input logic [POINT_W-1:0] pts_i, input logic [POINT_W-1:0] pts_j,
                               input logic [PROC_W-1:0] procs);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.points_i   <= pts_i;
      req_ch.points_j   <= pts_j;
      req_ch.proc_count <= procs;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // mostly small processor counts keep the divisor walk short
   task automatic send_random();
      int unsigned            pick;
      logic [PROC_W-1:0]      procs;
      logic [POINT_W-1:0]     pts[2];
      pick = $urandom_range(0, 99);
      if (pick < 80)
         procs = PROC_W'($urandom_range(0, 64));
      else if (pick < 97)
         procs = PROC_W'($urandom_range(1, 512));
      else
         procs = PROC_W'($urandom_range(0, 8191));
      for (int n = 0; n < 2; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            pts[n] = POINT_W'($urandom_range(0, 65535));
         else if (pick < 90)
            pts[n] = POINT_W'($urandom_range(1, 400));
         else
            pts[n] = POINT_W'($urandom_range(0, 20));
      end
      send_request(pts[0], pts[1], procs);
   endtask

   task automatic write_padding(input logic [PAD_W-1:0] width);
      csr_ch.valid         <= 1'b1;
      csr_ch.padding_width <= width;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (waiting_total != 0);
   endtask

   initial begin
      logic [PAD_W-1:0] phase_pad[PHASES];
      phase_pad = '{PAD_RESET, 4'd0, 4'd15, 4'd1, 4'd9, PAD_W'($urandom_range(1, 14))};
      reset                <= 1'b1;
      hold_go              <= 1'b0;
      send_idle_pct        <= 0;
      recv_idle_pct        <= 0;
      req_ch.valid         <= 1'b0;
      req_ch.points_i      <= '0;
      req_ch.points_j      <= '0;
      req_ch.proc_count    <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.padding_width <= PAD_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 2) begin
            send_idle_pct <= 38;
            recv_idle_pct <= 54;
         end else if (phase < 4) begin
            send_idle_pct <= 54;
            recv_idle_pct <= 38;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         if (phase != 0)
            write_padding(phase_pad[phase]);

         if (phase == 0) begin
            send_request(16'd1, 16'd1, 13'd1);          // too few points for any split
            send_request(16'd2, 16'd2, 13'd1);
            send_request(16'hFFFF, 16'hFFFF, 13'd4096);
            send_request(16'hFFFF, 16'd1, 13'd4);
            send_request(16'd0, 16'd100, 13'd4);
            send_request(16'd100, 16'd0, 13'd4);
            send_request(16'd100, 16'd100, 13'd0);
            send_request(16'd100, 16'd100, 13'd4097);   // refused, over the processor cap
            send_request(16'hFFFF, 16'hFFFF, 13'h1FFF);
            send_request(16'd1000, 16'd10, 13'd12);
            send_request(16'd10, 16'd1000, 13'd12);
            send_request(16'd64, 16'd64, 13'd16);
            send_request(16'd7, 16'd7, 13'd13);
            send_request(16'd100, 16'd50, 13'd6);
            send_request(16'd50, 16'd50, 13'd2);        // equal cost, lower p1 wins
            send_request(16'hAAAA, 16'h5555, 13'h0AAA);
            send_request(16'h5555, 16'hAAAA, 13'h0555);
            send_request(16'hFFFF, 16'hFFFF, 13'd1);
            send_request(16'd2, 16'hFFFF, 13'd2048);

            // sink stalls while requests keep coming, so the block backs up
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
            for (int n = 0; n < 4; n++)
               send_request(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                            13'($urandom_range(1, 8)));
         end

         repeat (PHASE_ITEMS) send_random();
         req_ch.valid <= 1'b0;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && waiting_total == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/pgf_pkg.sv
rtl/pgf_if.sv
rtl/processor_grid_factorizer_unit.sv
verif/pgf_split_checker.sv
verif/processor_grid_factorizer_unit_tb.sv
